@@ rtl/serial_command_filter_fifo_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the serial command filter.
// Each macro expands to a concurrent assertion in simulation and to
// nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_FILTER_FIFO_TOP_MACROS_SVH
`define SERIAL_COMMAND_FILTER_FIFO_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/scf_pkg.sv @@
// ---------------------------------------------------------------------------
// scf_pkg
// Types and constants shared by the serial command filter modules.
// ---------------------------------------------------------------------------
package scf_pkg;

  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 3;
  localparam int CNT_W   = 7;
  localparam int REPLY_W = 2;
  localparam int HCNT_W  = 3;
  localparam int CFG_AW  = 1;

  localparam logic [CMD_W-1:0] CMD_RX   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOCK = 3'd4;

  localparam logic [CFG_AW-1:0] REG_OPEN_HOUR  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_CLOSE_HOUR = 1'b1;

  localparam logic [BYTE_W-1:0] CH_S = 8'h53;
  localparam logic [BYTE_W-1:0] CH_T = 8'h54;
  localparam logic [BYTE_W-1:0] CH_L = 8'h4C;
  localparam logic [BYTE_W-1:0] CH_H = 8'h48;

  localparam logic [BYTE_W-1:0] OPEN_HOUR_RST  = 8'd8;
  localparam logic [BYTE_W-1:0] CLOSE_HOUR_RST = 8'd20;

  localparam logic [REPLY_W-1:0] REPLY_HOUR   = 2'd0;
  localparam logic [REPLY_W-1:0] REPLY_LOCK   = 2'd1;
  localparam logic [REPLY_W-1:0] REPLY_UNLOCK = 2'd2;

  localparam logic [HCNT_W-1:0] HCNT_IDLE  = 3'd0;
  localparam logic [HCNT_W-1:0] HCNT_FIRST = 3'd1;
  localparam logic [HCNT_W-1:0] HCNT_START = 3'd2;
  localparam logic [HCNT_W-1:0] HCNT_HOUR  = 3'd4;
  localparam logic [HCNT_W-1:0] HCNT_LAST  = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic              lock_value;
  } item_t;

  typedef struct packed {
    logic               pop_valid;
    logic [CNT_W-1:0]   fifo_count;
    logic               locked;
    logic               reply_pending;
    logic [REPLY_W-1:0] reply_code;
  } res_t;

endpackage

@@ rtl/serial_command_filter_fifo_top.sv @@
// ---------------------------------------------------------------------------
// serial_command_filter_fifo_top
// Serial command filter with a receive ring buffer and lock control.
// ---------------------------------------------------------------------------
// Each request gives exactly one result; the request is held in item_r and
// its result in res_r. A new request is taken every cycle unless the output
// stalls, or a held 'S' is followed by an ordinary byte and both bytes fit:
// the ring memory has a single write port, so the second byte is written in
// the following cycle and the input is not ready while that item advances.
// The ring holds DEPTH-1 bytes; its memory needs no clearing after reset.
`include "serial_command_filter_fifo_top_macros.svh"

module serial_command_filter_fifo_top #(
  parameter int DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [scf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [7:0]                 cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,  // rx_byte, lock_value, zero pad
  input  logic [2:0]                 in_tuser,  // cmd
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // pop_valid, pop_byte, fifo_count, locked, reply_pending, reply_code, zero pad
  output logic [23:0]                out_tdata
);
  import scf_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              a_valid_r, b_valid_r;
  item_t             item_r;
  res_t              res, res_r;
  logic              adv, dbl, in_acc;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata, pop_byte;

  assign adv       = a_valid_r && (!b_valid_r || out_tready);
  assign in_tready = !a_valid_r || (adv && !dbl);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        a_valid_r <= 1'b1;
      end else if (adv) begin
        a_valid_r <= 1'b0;
      end
      if (adv) begin
        b_valid_r <= 1'b1;
      end else if (out_tready) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.cmd        <= in_tuser;
      item_r.rx_byte    <= in_tdata[7:0];
      item_r.lock_value <= in_tdata[8];
    end
    if (adv) begin
      res_r <= res;
    end
  end

  scf_engine #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .item     (item_r),
    .adv      (adv),
    .dbl      (dbl),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr)
  );

  scf_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (BYTE_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (adv),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign pop_byte   = res_r.pop_valid ? mem_rdata : '0;
  assign out_tvalid = b_valid_r;
  assign out_tdata  = {4'b0000, res_r.reply_code, res_r.reply_pending, res_r.locked,
                       res_r.fifo_count, pop_byte, res_r.pop_valid};

  `SCF_ASSERT_NXT(a_dbl_bubble, clk, rst_n, adv && dbl, !a_valid_r)

endmodule

@@ rtl/scf_ram.sv @@
// ---------------------------------------------------------------------------
// scf_ram
// Byte store of the receive ring, one write port and one registered read.
// ---------------------------------------------------------------------------
module scf_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/scf_engine.sv @@
// ---------------------------------------------------------------------------
// scf_engine
// Command decoder, ring pointers, lock and reply state of the filter.
// ---------------------------------------------------------------------------
`include "serial_command_filter_fifo_top_macros.svh"

module scf_engine #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [scf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [scf_pkg::BYTE_W-1:0] cfg_wdata,
  input  scf_pkg::item_t            item,
  input  logic                      adv,
  output logic                      dbl,
  output scf_pkg::res_t             res,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [scf_pkg::BYTE_W-1:0] mem_wdata,
  output logic [AW-1:0]             mem_raddr
);
  import scf_pkg::*;

  localparam int CW = (AW > CNT_W) ? AW : CNT_W;

  logic [AW-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic               s_r, s_nxt;
  logic [HCNT_W-1:0]  hc_r, hc_nxt;
  logic [BYTE_W-1:0]  hl_r, hl_nxt;
  logic               lock_r, lock_nxt;
  logic               pend_flag_r, pend_flag_nxt;
  logic [REPLY_W-1:0] reply_r, reply_nxt;
  logic [BYTE_W-1:0]  open_r, close_r;
  logic               wr_pend_r;
  logic [AW-1:0]      wr_pend_addr_r;
  logic [BYTE_W-1:0]  wr_pend_data_r;
  logic               wr1;
  logic [AW-1:0]      wa1;
  logic [BYTE_W-1:0]  wd1;
  logic               pop_v;
  logic [AW-1:0]      wp_inc, wp_inc2;
  logic [AW:0]        cnt_w;
  logic [CW-1:0]      cnt_ext;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wp_inc  = ptr_inc(wp_r);
  assign wp_inc2 = ptr_inc(wp_inc);

  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    s_nxt         = s_r;
    hc_nxt        = hc_r;
    hl_nxt        = hl_r;
    lock_nxt      = lock_r;
    pend_flag_nxt = pend_flag_r;
    reply_nxt     = reply_r;
    wr1           = 1'b0;
    wa1           = wp_r;
    wd1           = item.rx_byte;
    dbl           = 1'b0;
    pop_v         = 1'b0;
    case (item.cmd)
      CMD_RX: begin
        if (hc_r >= HCNT_FIRST && hc_r <= HCNT_LAST) begin
          if (hc_r == HCNT_HOUR) begin
            hl_nxt = item.rx_byte;
          end
          if (hc_r == HCNT_LAST) begin
            lock_nxt      = (hl_r < open_r) || (hl_r >= close_r);
            pend_flag_nxt = 1'b1;
            reply_nxt     = REPLY_HOUR;
            hc_nxt        = HCNT_IDLE;
          end else begin
            hc_nxt = hc_r + 1'b1;
          end
        end else if (s_r) begin
          s_nxt = 1'b0;
          if (item.rx_byte == CH_T) begin
            lock_nxt      = 1'b1;
            pend_flag_nxt = 1'b1;
            reply_nxt     = REPLY_LOCK;
          end else if (item.rx_byte == CH_L) begin
            lock_nxt      = 1'b0;
            pend_flag_nxt = 1'b1;
            reply_nxt     = REPLY_UNLOCK;
          end else if (item.rx_byte == CH_H) begin
            hc_nxt = HCNT_START;
          end else if (wp_inc != rp_r) begin
            wr1    = 1'b1;
            wd1    = CH_S;
            wp_nxt = wp_inc;
            if (wp_inc2 != rp_r) begin
              dbl    = 1'b1;
              wp_nxt = wp_inc2;
            end
          end
        end else if (item.rx_byte == CH_S) begin
          s_nxt = 1'b1;
        end else if (wp_inc != rp_r) begin
          wr1    = 1'b1;
          wp_nxt = wp_inc;
        end
      end
      CMD_POP: begin
        if (wp_r != rp_r) begin
          pop_v  = 1'b1;
          rp_nxt = ptr_inc(rp_r);
        end
      end
      CMD_CLR: begin
        wp_nxt = '0;
        rp_nxt = '0;
      end
      CMD_ACK: begin
        pend_flag_nxt = 1'b0;
      end
      CMD_LOCK: begin
        lock_nxt = item.lock_value;
      end
      default: begin
      end
    endcase
  end

  assign cnt_w = {1'b0, wp_nxt} - {1'b0, rp_nxt}
               + ((wp_nxt < rp_nxt) ? (AW+1)'(DEPTH) : '0);
  assign cnt_ext = CW'(cnt_w[AW-1:0]);

  assign res.pop_valid     = pop_v;
  assign res.fifo_count    = cnt_ext[CNT_W-1:0];
  assign res.locked        = lock_nxt;
  assign res.reply_pending = pend_flag_nxt;
  assign res.reply_code    = reply_nxt;

  assign mem_we    = wr_pend_r || (adv && wr1);
  assign mem_waddr = wr_pend_r ? wr_pend_addr_r : wa1;
  assign mem_wdata = wr_pend_r ? wr_pend_data_r : wd1;
  assign mem_raddr = rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= OPEN_HOUR_RST;
      close_r <= CLOSE_HOUR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OPEN_HOUR:  open_r  <= cfg_wdata;
        REG_CLOSE_HOUR: close_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      s_r         <= 1'b0;
      hc_r        <= HCNT_IDLE;
      hl_r        <= '0;
      lock_r      <= 1'b0;
      pend_flag_r <= 1'b0;
      reply_r     <= REPLY_HOUR;
      wr_pend_r   <= 1'b0;
    end else begin
      wr_pend_r <= adv && dbl;
      if (adv) begin
        wp_r        <= wp_nxt;
        rp_r        <= rp_nxt;
        s_r         <= s_nxt;
        hc_r        <= hc_nxt;
        hl_r        <= hl_nxt;
        lock_r      <= lock_nxt;
        pend_flag_r <= pend_flag_nxt;
        reply_r     <= reply_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && dbl) begin
      wr_pend_addr_r <= wp_inc;
      wr_pend_data_r <= item.rx_byte;
    end
  end

  `SCF_ASSERT_IMP(a_hcnt_range, clk, rst_n, 1'b1, hc_r != 3'd6 && hc_r != 3'd7)
  `SCF_ASSERT_NXT(a_ack_clears, clk, rst_n, adv && item.cmd == CMD_ACK, !pend_flag_r)
  `SCF_ASSERT_IMP(a_pend_src, clk, rst_n, wr_pend_r, $past(adv) && !adv)

endmodule
